@@ rtl/mtg_pkg.sv @@
// mtg_pkg: constants, command and status types shared by the mt19937 generator
// used by mtg_ram, mtg_ctrl, mtg_dp and the top level; no dependencies
`default_nettype none

package mtg_pkg;

  localparam int WORD_W       = 32;
  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;

  localparam logic [WORD_W-1:0] SEED_MULT    = 32'h6C07_8965;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [WORD_W-1:0] UPPER_BIT    = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_BITS   = 32'h7FFF_FFFF;

  // table read address select
  typedef enum logic [1:0] {
    RD_CUR,
    RD_NXT,
    RD_FAR
  } rd_sel_t;

  typedef struct packed {
    logic    load_seed;
    logic    seed_wr0;
    logic    seed_mul;
    logic    seed_add;
    rd_sel_t rd_sel;
    logic    cap_cur;
    logic    cap_nxt;
    logic    twist;
    logic    emit;
  } mtg_cmd_t;

  typedef struct packed {
    logic seed_last;
    logic out_free;
  } mtg_status_t;

endpackage

`default_nettype wire

@@ rtl/mtg_ram.sv @@
// mtg_ram: generic simple dual-port ram, one write and one registered read per cycle
// depends on mtg_pkg for default sizes
`default_nettype none

module mtg_ram #(
  parameter int WIDTH = mtg_pkg::WORD_W,
  parameter int DEPTH = mtg_pkg::STATE_WORDS
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/mtg_ctrl.sv @@
// mtg_ctrl: sequencer for seed and draw transactions of the mt19937 generator
// depends on mtg_pkg (command and status types)
`default_nettype none

module mtg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_func,
  output logic                      in_ready,
  input  wire mtg_pkg::mtg_status_t status,
  output mtg_pkg::mtg_cmd_t         cmd
);

  typedef enum logic [3:0] {
    IDLE,
    SEED_FIRST,
    SEED_MUL,
    SEED_ADD,
    DRAW_CUR,
    DRAW_NXT,
    DRAW_FAR,
    DRAW_TWIST,
    DRAW_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;
  logic   accept;

  assign in_ready = in_ready_r;
  assign accept   = in_valid && in_ready_r;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.rd_sel = mtg_pkg::RD_CUR;
    unique case (state_r)
      IDLE: begin
        if (accept) begin
          if (in_func) begin
            state_nxt = DRAW_CUR;
          end else begin
            cmd.load_seed = 1'b1;
            state_nxt     = SEED_FIRST;
          end
        end
      end
      SEED_FIRST: begin
        cmd.seed_wr0 = 1'b1;
        state_nxt    = SEED_MUL;
      end
      SEED_MUL: begin
        cmd.seed_mul = 1'b1;
        state_nxt    = SEED_ADD;
      end
      SEED_ADD: begin
        cmd.seed_add = 1'b1;
        state_nxt    = status.seed_last ? IDLE : SEED_MUL;
      end
      DRAW_CUR: begin
        cmd.rd_sel = mtg_pkg::RD_CUR;
        state_nxt  = DRAW_NXT;
      end
      DRAW_NXT: begin
        cmd.rd_sel  = mtg_pkg::RD_NXT;
        cmd.cap_cur = 1'b1;
        state_nxt   = DRAW_FAR;
      end
      DRAW_FAR: begin
        cmd.rd_sel  = mtg_pkg::RD_FAR;
        cmd.cap_nxt = 1'b1;
        state_nxt   = DRAW_TWIST;
      end
      DRAW_TWIST: begin
        cmd.twist = 1'b1;
        state_nxt = DRAW_EMIT;
      end
      DRAW_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: begin
        state_nxt = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == IDLE);
    end
  end

endmodule

`default_nettype wire

@@ rtl/mtg_dp.sv @@
// mtg_dp: state table, seed recurrence, lazy per-word twist, tempering, output register
// depends on mtg_pkg and mtg_ram
`default_nettype none

module mtg_dp #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [mtg_pkg::WORD_W-1:0]  in_seed_value,
  input  wire mtg_pkg::mtg_cmd_t           cmd,
  output mtg_pkg::mtg_status_t             status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [mtg_pkg::WORD_W-1:0]  out_random_word
);

  localparam int IDX_W = $clog2(STATE_WORDS);
  localparam int SUM_W = IDX_W + 1;
  localparam int W     = mtg_pkg::WORD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
  localparam logic [SUM_W-1:0] OFFSET   = SUM_W'(mtg_pkg::TWIST_OFFSET);
  localparam logic [SUM_W-1:0] WRAP     = SUM_W'(STATE_WORDS);

  function automatic logic [W-1:0] temper(input logic [W-1:0] y_in);
    logic [W-1:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // control state
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] sidx_r;
  logic             seeded_r;
  logic             raw_r;
  logic             out_valid_r;

  // payload
  logic [W-1:0] p_r, prod_r, cur_r, nxt_r, word_r, out_word_r;

  logic [IDX_W-1:0] nxt_idx, far_idx;
  logic [SUM_W-1:0] far_sum;
  logic [W-1:0]     seed_mix, prod_nxt, seed_word;
  logic [W-1:0]     y, twist_val, rdata;
  logic             raw_eff;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [W-1:0]     wdata;

  // neighbor and far addresses, modulo the table depth
  assign nxt_idx = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign far_sum = {1'b0, idx_r} + OFFSET;
  assign far_idx = (far_sum >= WRAP) ? IDX_W'(far_sum - WRAP) : far_sum[IDX_W-1:0];
  assign idx_nxt = nxt_idx;

  // seed recurrence, multiply then add
  assign seed_mix  = p_r ^ (p_r >> 30);
  assign prod_nxt  = seed_mix * mtg_pkg::SEED_MULT;
  assign seed_word = prod_r + {{(W - IDX_W){1'b0}}, sidx_r};

  // twist of one word; words left over from a mid-round seed are used untwisted
  assign y         = (cur_r & mtg_pkg::UPPER_BIT) | (nxt_r & mtg_pkg::LOWER_BITS);
  assign twist_val = rdata ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);
  assign raw_eff   = raw_r && (idx_r != '0);

  always_comb begin
    unique case (cmd.rd_sel)
      mtg_pkg::RD_CUR: raddr = idx_r;
      mtg_pkg::RD_NXT: raddr = nxt_idx;
      mtg_pkg::RD_FAR: raddr = far_idx;
      default:         raddr = idx_r;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = twist_val;
    priority if (cmd.seed_wr0) begin
      we    = 1'b1;
      waddr = '0;
      wdata = p_r;
    end else if (cmd.seed_add) begin
      we    = 1'b1;
      waddr = sidx_r;
      wdata = seed_word;
    end else if (cmd.twist) begin
      we    = seeded_r && !raw_eff;
    end else begin
      we    = 1'b0;
    end
  end

  mtg_ram #(
    .WIDTH (W),
    .DEPTH (STATE_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign status.seed_last = (sidx_r == LAST_IDX);
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_seed) begin
      p_r <= in_seed_value;
    end else if (cmd.seed_add) begin
      p_r <= seed_word;
    end
    if (cmd.seed_mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.cap_cur) begin
      cur_r <= rdata;
    end
    if (cmd.cap_nxt) begin
      nxt_r <= rdata;
    end
    if (cmd.twist) begin
      // an unseeded table gives zero words and is not written by the twist
      if (!seeded_r) begin
        word_r <= '0;
      end else if (raw_eff) begin
        word_r <= cur_r;
      end else begin
        word_r <= twist_val;
      end
    end
    if (cmd.emit) begin
      out_word_r <= temper(word_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      sidx_r      <= '0;
      seeded_r    <= 1'b0;
      raw_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.seed_wr0) begin
        sidx_r <= IDX_W'(1);
      end else if (cmd.seed_add && !status.seed_last) begin
        sidx_r <= sidx_r + 1'b1;
      end
      if (cmd.seed_add && status.seed_last) begin
        seeded_r <= 1'b1;
        raw_r    <= 1'b1;
      end else if (cmd.emit && (idx_r == '0)) begin
        raw_r <= 1'b0;
      end
      if (cmd.emit) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

endmodule

`default_nettype wire

@@ rtl/mersenne_twister_generator_unit.sv @@
// mersenne_twister_generator_unit: top level of the 32-bit mt19937 generator
// depends on mtg_pkg, mtg_ctrl, mtg_dp (which holds mtg_ram)
`default_nettype none

// MT19937 word generator with a 624-word state table held in one simple
// dual-port ram. A transaction with in_func = 0 reseeds the table from
// in_seed_value and gives no result; with in_func = 1 it gives one tempered
// 32-bit word on the out_ channel. The twist is done lazily, one word per draw,
// which matches a full in-place regeneration at index zero; words still ahead
// of the read index after a mid-round reseed are delivered untwisted, and a
// draw before any reseed returns zero. In a draw the table's single read port
// serves three reads (the word, its neighbor and the word 397 ahead) in turn,
// then the twist state twists and writes back the word and the emit state
// tempers it into the output register. A reseed first writes the seed word,
// then does one multiply and one add for each of the 623 words after the
// first, with the single 32x32 multiplier registered between them. No
// clearing pass is needed after reset. The output register lets the next
// transaction be accepted while a result still waits; a draw that finishes
// while the register is full holds until it drains.
module mersenne_twister_generator_unit #(
  parameter int STATE_WORDS = mtg_pkg::STATE_WORDS
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // input channel
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_func,
  input  wire logic [mtg_pkg::WORD_W-1:0] in_seed_value,
  // result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [mtg_pkg::WORD_W-1:0] out_random_word
);

  // command and status between sequencer and datapath
  mtg_pkg::mtg_cmd_t    cmd;
  mtg_pkg::mtg_status_t status;

  mtg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mtg_dp #(
    .STATE_WORDS (STATE_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_seed_value   (in_seed_value),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_word (out_random_word)
  );

endmodule

`default_nettype wire

@@ rtl/mtg_checker.sv @@
// mtg_checker: port-level assertions for the mt19937 generator top level
// bound to mersenne_twister_generator_unit; no package dependency
`default_nettype none

module mtg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_func,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_random_word
);

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_random_word))
    else $error("result changed or dropped while stalled");

  // ready drops after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after a transaction");

  // a reseed never produces a result
  a_seed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_func && !out_valid |=> !out_valid)
    else $error("result appeared after a reseed");

  // a draw accepted while the output register is empty always delivers a result
  a_draw_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func && !out_valid |-> ##6 out_valid)
    else $error("draw result missing");

endmodule

bind mersenne_twister_generator_unit mtg_checker u_mtg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_func         (in_func),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_random_word (out_random_word)
);

`default_nettype wire
